// ----- rtl/hse_pkg.sv -----
// Package with shared constants and command/status types of the heap sort engine.
`default_nettype none
package hse_pkg;
    localparam int DEPTH_DEFAULT = 64;
    localparam int KEY_WIDTH_DEFAULT = 32;

    typedef struct packed {
        logic load;      // store the incoming key
        logic out_take;  // the result register was taken
    } hse_cmd_t;

    typedef struct packed {
        logic busy;      // sorting or emitting
    } hse_stat_t;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_CLOSE,
        OP_TOP,
        OP_RDN,
        OP_KID1,
        OP_KID2,
        OP_CMP,
        OP_WRN,
        OP_WRK,
        OP_EXR,
        OP_EXK,
        OP_EXW,
        OP_WRR,
        OP_EMRD,
        OP_EMIT
    } hse_op_t;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic top_zero;   // no parent left to sift in the build phase
        logic len_le1;    // heap has shrunk to one entry
        logic kid1_out;   // node has no children
        logic kid2_in;    // node has a right child
        logic kid2_wins;  // right child is larger than the left one
        logic node_wins;  // node is not smaller than its larger child
        logic emit_last;  // the entry being emitted is the final one
        logic out_free;   // the result register can take a new item
    } hse_dst_t;
endpackage
`default_nettype wire

// ----- rtl/hse_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH+1)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0] idx;
    assign idx = addr[AW-1:0];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[idx] <= wdata;
        end
        rdata <= mem[idx];
    end
endmodule
`default_nettype wire

// ----- rtl/hse_core.sv -----
// Controller state machine and datapath of the heap sort engine.
`default_nettype none
module hse_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire logic              in_last,
    input  wire hse_pkg::hse_dst_t dst,
    output hse_pkg::hse_stat_t     stat,
    output hse_pkg::hse_op_t       op,
    output logic                   take_node
);
    typedef enum logic [13:0] {
        ST_LOAD  = 14'b00000000000001,
        ST_BUILD = 14'b00000000000010,
        ST_RDN   = 14'b00000000000100,
        ST_RDK   = 14'b00000000001000,
        ST_RDK2  = 14'b00000000010000,
        ST_CMP   = 14'b00000000100000,
        ST_WRN   = 14'b00000001000000,
        ST_WRK   = 14'b00000010000000,
        ST_EXR   = 14'b00000100000000,
        ST_EXK   = 14'b00001000000000,
        ST_EXW   = 14'b00010000000000,
        ST_WRR   = 14'b00100000000000,
        ST_EMRD  = 14'b01000000000000,
        ST_EMIT  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic phase_reg, phase_next;   // 0 build, 1 extract

    assign stat.busy = (state_reg != ST_LOAD);

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        op = hse_pkg::OP_IDLE;
        take_node = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                if (load) begin
                    if (in_last) begin
                        op = hse_pkg::OP_CLOSE;
                        phase_next = 1'b0;
                        state_next = ST_BUILD;
                    end else begin
                        op = hse_pkg::OP_LOAD;
                    end
                end
            end
            ST_BUILD: begin
                // Build phase walks the parents down; afterwards every sift starts an exchange.
                if (phase_reg || dst.top_zero) begin
                    phase_next = 1'b1;
                    state_next = ST_EXR;
                end else begin
                    op = hse_pkg::OP_TOP;
                    state_next = ST_RDN;
                end
            end
            ST_RDN: begin
                op = hse_pkg::OP_RDN;
                state_next = ST_RDK;
            end
            ST_RDK: begin
                // Only a freshly read parent loads the sifted key from the RAM.
                op = hse_pkg::OP_KID1;
                take_node = !phase_reg;
                state_next = dst.kid1_out ? ST_BUILD : ST_RDK2;
            end
            ST_RDK2: begin
                op = hse_pkg::OP_KID2;
                state_next = dst.kid2_in ? ST_CMP : ST_WRN;
            end
            ST_CMP: begin
                op = hse_pkg::OP_CMP;
                state_next = ST_WRN;
            end
            ST_WRN: begin
                if (dst.node_wins) begin
                    state_next = ST_BUILD;
                end else begin
                    op = hse_pkg::OP_WRN;
                    state_next = ST_WRK;
                end
            end
            ST_WRK: begin
                op = hse_pkg::OP_WRK;
                state_next = ST_RDK;
            end
            ST_EXR: begin
                if (dst.len_le1) begin
                    state_next = ST_EMRD;
                end else begin
                    op = hse_pkg::OP_EXR;
                    state_next = ST_EXK;
                end
            end
            ST_EXK: begin
                op = hse_pkg::OP_EXK;
                state_next = ST_EXW;
            end
            ST_EXW: begin
                op = hse_pkg::OP_EXW;
                state_next = ST_WRR;
            end
            ST_WRR: begin
                op = hse_pkg::OP_WRR;
                state_next = ST_RDK;
            end
            ST_EMRD: begin
                op = hse_pkg::OP_EMRD;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                op = hse_pkg::OP_EMIT;
                if (dst.out_free && dst.emit_last) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end
endmodule

module hse_dp #(
    parameter int DEPTH = hse_pkg::DEPTH_DEFAULT,
    parameter int KEY_WIDTH = hse_pkg::KEY_WIDTH_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire hse_pkg::hse_op_t     op,
    input  wire logic                 take_node,
    input  wire logic                 out_take,
    input  wire logic [KEY_WIDTH-1:0] in_key,
    input  wire logic                 key_is_signed,
    output hse_pkg::hse_dst_t         dst,
    output logic                      out_valid,
    output logic [KEY_WIDTH-1:0]      out_key,
    output logic                      out_end,
    output logic                      out_drop
);
    localparam int CW = $clog2(DEPTH+1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] top_reg, top_next;
    logic [CW-1:0] node_reg, node_next;
    logic [CW-1:0] kid_reg, kid_next;
    logic [CW-1:0] emit_reg, emit_next;
    logic [CW-1:0] cnt_inc;
    logic [KEY_WIDTH-1:0] nval_reg, nval_next, kval_reg, kval_next;
    logic ovf_reg, ovf_next, sgn_reg, sgn_next;
    logic ov_reg, ov_next, oe_reg, oe_next, od_reg, od_next;
    logic [KEY_WIDTH-1:0] ok_reg, ok_next;
    logic room;

    logic we;
    logic [CW-1:0] addr;
    logic [KEY_WIDTH-1:0] wdata, rdata;

    hse_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    function automatic logic lt(input logic [KEY_WIDTH-1:0] a,
                                input logic [KEY_WIDTH-1:0] b, input logic s);
        logic [KEY_WIDTH-1:0] fa, fb;
        begin
            fa = a;
            fb = b;
            fa[KEY_WIDTH-1] = a[KEY_WIDTH-1] ^ s;
            fb[KEY_WIDTH-1] = b[KEY_WIDTH-1] ^ s;
            lt = fa < fb;
        end
    endfunction

    logic [CW:0] kid1, kid2;
    assign kid1 = {node_reg, 1'b1};
    assign kid2 = kid1 + (CW+1)'(1);

    assign room = (cnt_reg < CW'(DEPTH));
    assign cnt_inc = room ? cnt_reg + CW'(1) : cnt_reg;

    assign dst.top_zero = (top_reg == '0);
    assign dst.len_le1 = (len_reg <= CW'(1));
    assign dst.kid1_out = (kid1 >= (CW+1)'(len_reg));
    assign dst.kid2_in = (kid2 < (CW+1)'(len_reg));
    assign dst.kid2_wins = lt(kval_reg, rdata, sgn_reg);
    assign dst.node_wins = !lt(nval_reg, kval_reg, sgn_reg);
    assign dst.emit_last = (emit_reg + CW'(1) == cnt_reg);
    assign dst.out_free = !ov_reg || out_take;

    assign out_valid = ov_reg;
    assign out_key = ok_reg;
    assign out_end = oe_reg;
    assign out_drop = od_reg;

    always_comb begin
        cnt_next = cnt_reg; len_next = len_reg; top_next = top_reg;
        node_next = node_reg; kid_next = kid_reg; emit_next = emit_reg;
        nval_next = nval_reg; kval_next = kval_reg;
        ovf_next = ovf_reg; sgn_next = sgn_reg;
        ov_next = ov_reg; oe_next = oe_reg; od_next = od_reg; ok_next = ok_reg;
        we = 1'b0; addr = cnt_reg; wdata = in_key;
        if (out_take) begin
            ov_next = 1'b0;
        end
        unique case (op) inside
            hse_pkg::OP_IDLE: ;
            hse_pkg::OP_LOAD, hse_pkg::OP_CLOSE: begin
                // A key that finds the store full is dropped and flagged.
                we = room;
                cnt_next = cnt_inc;
                if (!room) begin
                    ovf_next = 1'b1;
                end
                if (op == hse_pkg::OP_CLOSE) begin
                    sgn_next = key_is_signed;
                    len_next = cnt_inc;
                    top_next = cnt_inc >> 1;
                    emit_next = '0;
                end
            end
            hse_pkg::OP_TOP: begin
                node_next = top_reg - CW'(1);
                top_next = top_reg - CW'(1);
            end
            hse_pkg::OP_RDN: begin
                addr = node_reg;
            end
            hse_pkg::OP_KID1: begin
                if (take_node) begin
                    nval_next = rdata;
                end
                addr = kid1[CW-1:0];
                kid_next = kid1[CW-1:0];
            end
            hse_pkg::OP_KID2: begin
                kval_next = rdata;
                addr = kid2[CW-1:0];
            end
            hse_pkg::OP_CMP: begin
                if (dst.kid2_wins) begin
                    kval_next = rdata;
                    kid_next = kid2[CW-1:0];
                end
            end
            hse_pkg::OP_WRN: begin
                we = 1'b1;
                addr = kid_reg;
                wdata = nval_reg;
            end
            hse_pkg::OP_WRK: begin
                we = 1'b1;
                addr = node_reg;
                wdata = kval_reg;
                node_next = kid_reg;
            end
            hse_pkg::OP_EXR: begin
                // Read the root; the end of the heap is read next.
                addr = '0;
                kid_next = len_reg - CW'(1);
                node_next = '0;
            end
            hse_pkg::OP_EXK: begin
                nval_next = rdata;
                addr = kid_reg;
            end
            hse_pkg::OP_EXW: begin
                we = 1'b1;
                addr = kid_reg;
                wdata = nval_reg;
                kval_next = rdata;
                len_next = len_reg - CW'(1);
            end
            hse_pkg::OP_WRR: begin
                // The former end key becomes the root and is sifted down.
                we = 1'b1;
                addr = '0;
                wdata = kval_reg;
                nval_next = kval_reg;
            end
            hse_pkg::OP_EMRD: begin
                addr = emit_reg;
            end
            hse_pkg::OP_EMIT: begin
                addr = emit_reg;
                if (dst.out_free) begin
                    ov_next = 1'b1;
                    ok_next = rdata;
                    oe_next = dst.emit_last;
                    od_next = ovf_reg;
                    if (dst.emit_last) begin
                        cnt_next = '0;
                        ovf_next = 1'b0;
                    end else begin
                        emit_next = emit_reg + CW'(1);
                        addr = emit_reg + CW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            ov_reg <= ov_next;
        end
        len_reg <= len_next; top_reg <= top_next; node_reg <= node_next;
        kid_reg <= kid_next; emit_reg <= emit_next; nval_reg <= nval_next;
        kval_reg <= kval_next; sgn_reg <= sgn_next; oe_reg <= oe_next;
        od_reg <= od_next; ok_reg <= ok_next;
    end
endmodule
`default_nettype wire

// ----- rtl/heap_sort_engine_top.sv -----
// Top level of the heap sort engine with stream ports and the sign register.
//
//  Channel | Dir | Content
//  s_      | in  | tdata = key, tlast = last
//  m_      | out | tdata = sorted_key, tlast = end_of_set, tuser = dropped
//  cfg_    | in  | cfg_data = key_is_signed
//
// Keys are loaded while the engine is idle. After the last key the single RAM
// port runs the sift sequencer: it builds the heap by sifting each parent down,
// then exchanges the root with the end of the heap and sifts again for each key;
// results then follow one a cycle while the output is not stalled.
// Reset is synchronous and clears the key count and flags; the store needs no clearing.
// Input is held off while sorting and emitting; output stalls freeze emission.
`default_nettype none
module heap_sort_engine_top #(
    parameter int DEPTH = hse_pkg::DEPTH_DEFAULT,
    parameter int KEY_WIDTH = hse_pkg::KEY_WIDTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // key[31:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // sorted_key[31:0]
    output logic             m_tlast,
    output logic             m_tuser,   // dropped
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);
    localparam int KB = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
    hse_pkg::hse_cmd_t cmd;
    hse_pkg::hse_stat_t stat;
    hse_pkg::hse_op_t op;
    hse_pkg::hse_dst_t dst;
    logic take_node;
    logic sgn_reg;
    logic [KB-1:0] okey;

    // The sign mode is a plain register; the sorter samples it when a set closes.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sgn_reg <= 1'b0;
        end else if (cfg_valid) begin
            sgn_reg <= cfg_data;
        end
    end

    // Keys are taken only while the controller is loading.
    assign s_tready = !stat.busy;
    assign cmd.load = s_tvalid && s_tready;
    assign cmd.out_take = m_tvalid && m_tready;

    hse_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .load(cmd.load), .in_last(s_tlast),
        .dst(dst), .stat(stat), .op(op), .take_node(take_node)
    );

    hse_dp #(.DEPTH(DEPTH), .KEY_WIDTH(KB)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .op(op), .take_node(take_node),
        .out_take(cmd.out_take), .in_key(s_tdata[KB-1:0]), .key_is_signed(sgn_reg),
        .dst(dst), .out_valid(m_tvalid), .out_key(okey), .out_end(m_tlast),
        .out_drop(m_tuser)
    );
    assign m_tdata = 32'(okey);
endmodule
`default_nettype wire

// ----- rtl/hse_checker.sv -----
// Port-level checker of the heap sort engine, bound to the top level.
`default_nettype none
module hse_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic s_tlast,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    a_nolast_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready) else $error("ready after last");
    a_noout_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid || m_tlast) else $error("output while loading");
endmodule
bind heap_sort_engine_top hse_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast)
);
`default_nettype wire
